@@ hw/rtl/pets_pkg.sv @@
// Shared types, constants and helper functions of the priority epoch thread scheduler.
`timescale 1ns / 1ps
package pets_pkg;

	// Table and list geometry.
	localparam int MAX_THREADS = 16;
	localparam int SLOT_W      = $clog2(MAX_THREADS);
	localparam int PRIO_LEVELS = 15;
	localparam int LVL_W       = $clog2(PRIO_LEVELS);
	localparam int NUM_LISTS   = 2 * PRIO_LEVELS;
	localparam int LIST_W      = $clog2(NUM_LISTS);

	// Reset quantum of the register and of the first thread.
	localparam logic [7:0] DEF_QUANT = 8'd5;

	// Division of the sleep time by ten: multiply by a reciprocal and shift.
	// The result is exact for every 16-bit operand.
	localparam logic [15:0] DIV_MUL   = 16'd52429;
	localparam int          DIV_SHIFT = 19;
	localparam int          TICKS_W   = 32 - DIV_SHIFT;

	// Command codes.
	typedef enum logic [2:0] {
		CMD_CREATE = 3'd0,
		CMD_TICK   = 3'd1,
		CMD_YIELD  = 3'd2,
		CMD_SLEEP  = 3'd3,
		CMD_EXIT   = 3'd4,
		CMD_NICE   = 3'd5
	} cmd_t;

	// Status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_IDLE = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_DONE = 2'd3;

	// One entry of the thread table memory.
	typedef struct packed {
		logic [LVL_W-1:0]   base;
		logic [LVL_W-1:0]   cur;
		logic [7:0]         quant;
		logic signed [5:0]  nice;
		logic [31:0]        wake;
	} thr_entry_t;

	// Clamp base plus nice to the level range.
	function automatic logic [LVL_W-1:0] clamp_sum(logic [LVL_W-1:0] base,
		logic signed [5:0] nice);
		logic signed [7:0] sum;
		sum = $signed({4'b0000, base}) + $signed({{2{nice[5]}}, nice});
		if (sum < 0) begin
			return '0;
		end else if (sum > 8'sd14) begin
			return LVL_W'(PRIO_LEVELS - 1);
		end
		return sum[LVL_W-1:0];
	endfunction

	// Clamp a signed priority request to the level range.
	function automatic logic [LVL_W-1:0] clamp_req(logic signed [5:0] req);
		if (req[5]) begin
			return '0;
		end else if (req > 6'sd14) begin
			return LVL_W'(PRIO_LEVELS - 1);
		end
		return req[LVL_W-1:0];
	endfunction

	// List index of a level in a bank.
	function automatic logic [LIST_W-1:0] list_idx(logic bank, logic [LVL_W-1:0] lvl);
		return bank ? (LIST_W'(lvl) + LIST_W'(PRIO_LEVELS)) : LIST_W'(lvl);
	endfunction

endpackage

@@ hw/rtl/priority_epoch_thread_scheduler_unit.sv @@
// Top level of the priority epoch thread scheduler.
`timescale 1ns / 1ps
// Path from the accepting edge to the result register: create and ignored commands go
// straight to it, set nice adds a charge, yield and sleep a charge and a dispatch, exit
// a dispatch, tick a 16-entry scan first. A dispatch that must follow a list link adds
// a head update; output stalls add more. Throughput: one request at a time; the next is
// taken in the idle state entered once the result is loaded. Before the first request,
// an init state writes thread 0. Reset leaves thread 0 running, quantum register at 5.
module priority_epoch_thread_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic signed [5:0] priority_req,
	input  logic signed [5:0] nice_value,
	input  logic [15:0] sleep_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  running_thread,
	output logic        running_valid,
	output logic [1:0]  status,
	output logic [3:0]  created_slot,
	output logic [3:0]  new_priority
);

	localparam int SW = pets_pkg::SLOT_W;
	localparam int LW = pets_pkg::LVL_W;
	localparam int IW = pets_pkg::LIST_W;
	localparam int NL = pets_pkg::NUM_LISTS;
	localparam int NT = pets_pkg::MAX_THREADS;
	localparam int PL = pets_pkg::PRIO_LEVELS;
	localparam int TICKS_SEL = pets_pkg::TICKS_W;

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_EXEC, S_TSCAN, S_CHG, S_DISP, S_POPW, S_FIN
	} state_t;

	state_t state_q;
	pets_pkg::cmd_t cmd_q;
	logic signed [5:0] prio_q, nice_q;
	logic [31:0] prod_q;
	logic [7:0] dq_q;
	logic [NT-1:0] use_q, sleep_q;
	logic [NL-1:0] ne_q;
	logic [SW-1:0] head_q [NL];
	logic [SW-1:0] tail_q [NL];
	logic epoch_q;
	logic [31:0] tick_q;
	logic [SW-1:0] run_slot_q;
	logic run_flag_q;
	logic [SW-1:0] chk_q;
	logic [IW-1:0] pli_q;
	logic full_q;
	logic [SW-1:0] nt_q;
	logic [LW-1:0] np_q;
	logic out_valid_q;
	logic [3:0] out_thread_q, out_nt_q, out_np_q;
	logic out_run_q;
	logic [1:0] out_stat_q;

	// Memory ports.
	logic thr_we;
	logic [SW-1:0] thr_waddr, thr_raddr;
	pets_pkg::thr_entry_t thr_wdata, thr_rdata;
	logic lnk_we;
	logic [SW-1:0] lnk_waddr, lnk_raddr, lnk_wdata, lnk_rdata;

	pets_ram #(.Width($bits(pets_pkg::thr_entry_t)), .Depth(NT)) u_thr_ram (
		.clk(clk), .we(thr_we), .waddr(thr_waddr), .wdata(thr_wdata),
		.raddr(thr_raddr), .rdata(thr_rdata)
	);

	pets_ram #(.Width(SW), .Depth(NT)) u_lnk_ram (
		.clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
		.raddr(lnk_raddr), .rdata(lnk_rdata)
	);

	// Lowest free slot.
	logic free_found;
	logic [SW-1:0] free_slot;
	always_comb begin
		free_found = 1'b0;
		free_slot = '0;
		for (int s = NT - 1; s >= 0; s--) begin
			if (!use_q[s]) begin
				free_found = 1'b1;
				free_slot = SW'(s);
			end
		end
	end

	// Highest priority non-empty list, swapping sets when the active set is empty.
	logic [PL-1:0] mask_a, mask_b, mask_sel;
	logic use_b, disp_found;
	logic [LW-1:0] disp_lvl;
	logic [IW-1:0] disp_li;
	always_comb begin
		for (int p = 0; p < PL; p++) begin
			mask_a[p] = ne_q[pets_pkg::list_idx(epoch_q, LW'(p))];
			mask_b[p] = ne_q[pets_pkg::list_idx(~epoch_q, LW'(p))];
		end
		use_b = (mask_a == '0);
		mask_sel = use_b ? mask_b : mask_a;
		disp_found = (mask_sel != '0);
		disp_lvl = '0;
		for (int p = PL - 1; p >= 0; p--) begin
			if (mask_sel[p]) begin
				disp_lvl = LW'(p);
			end
		end
		disp_li = pets_pkg::list_idx(use_b ? ~epoch_q : epoch_q, disp_lvl);
	end

	// Charge of the entry that was just read.
	logic refill;
	logic [LW-1:0] chg_cur;
	logic [7:0] chg_quant;
	logic [TICKS_SEL-1:0] ticks;
	logic scan_hit;
	always_comb begin
		refill = (thr_rdata.quant <= 8'd1);
		chg_cur = refill ? pets_pkg::clamp_sum(thr_rdata.base, thr_rdata.nice) : thr_rdata.cur;
		chg_quant = refill ? dq_q : (thr_rdata.quant - 8'd1);
		ticks = prod_q[31:pets_pkg::DIV_SHIFT];
		scan_hit = use_q[chk_q] && sleep_q[chk_q] && (thr_rdata.wake == tick_q);
	end

	// Memory control and list append.
	logic push_en;
	logic [IW-1:0] push_li;
	logic [SW-1:0] push_slot;
	always_comb begin
		thr_we = 1'b0;
		thr_waddr = run_slot_q;
		thr_wdata = thr_rdata;
		thr_raddr = run_slot_q;
		lnk_raddr = head_q[disp_li];
		push_en = 1'b0;
		push_li = '0;
		push_slot = run_slot_q;
		case (state_q)
			S_INIT: begin
				thr_we = 1'b1;
				thr_waddr = '0;
				thr_wdata = '{base: '0, cur: '0, quant: pets_pkg::DEF_QUANT, nice: '0,
					wake: '0};
			end
			S_EXEC: begin
				if (cmd_q == pets_pkg::CMD_CREATE && free_found) begin
					thr_we = 1'b1;
					thr_waddr = free_slot;
					thr_wdata = '{base: pets_pkg::clamp_req(prio_q),
						cur: pets_pkg::clamp_req(prio_q), quant: dq_q, nice: '0, wake: '0};
					push_en = 1'b1;
					push_li = pets_pkg::list_idx(epoch_q, pets_pkg::clamp_req(prio_q));
					push_slot = free_slot;
				end
				if (cmd_q == pets_pkg::CMD_TICK) begin
					thr_raddr = '0;
				end
			end
			S_TSCAN: begin
				thr_raddr = (chk_q == SW'(NT - 1)) ? run_slot_q : (chk_q + SW'(1));
				if (scan_hit) begin
					push_en = 1'b1;
					push_li = pets_pkg::list_idx(epoch_q, thr_rdata.cur);
					push_slot = chk_q;
				end
			end
			S_CHG: begin
				thr_we = 1'b1;
				if (cmd_q == pets_pkg::CMD_NICE) begin
					thr_wdata.nice = nice_q;
					thr_wdata.cur = pets_pkg::clamp_sum(thr_rdata.base, nice_q);
				end else begin
					thr_wdata.quant = chg_quant;
					thr_wdata.cur = chg_cur;
					if (cmd_q == pets_pkg::CMD_SLEEP) begin
						thr_wdata.wake = tick_q + 32'(ticks);
					end else begin
						push_en = 1'b1;
						push_li = refill ? pets_pkg::list_idx(~epoch_q, chg_cur)
							: pets_pkg::list_idx(epoch_q, thr_rdata.cur);
					end
				end
			end
			default: begin
			end
		endcase
		lnk_we = push_en && ne_q[push_li];
		lnk_waddr = tail_q[push_li];
		lnk_wdata = push_slot;
	end

	// Lists are kept apart from the sequencer so that each has one writer per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
		end else begin
			if (push_en) begin
				ne_q[push_li] <= 1'b1;
			end
			if (state_q == S_DISP && disp_found && head_q[disp_li] == tail_q[disp_li]) begin
				ne_q[disp_li] <= 1'b0;
			end
		end
	end

	// Head and tail pointers.
	always_ff @(posedge clk) begin
		if (push_en) begin
			tail_q[push_li] <= push_slot;
			if (!ne_q[push_li]) begin
				head_q[push_li] <= push_slot;
			end
		end
		if (state_q == S_POPW) begin
			head_q[pli_q] <= lnk_rdata;
		end
	end

	// Sequencer, scheduler registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			dq_q <= pets_pkg::DEF_QUANT;
			use_q <= NT'(1);
			sleep_q <= '0;
			epoch_q <= 1'b0;
			tick_q <= 32'd1;
			run_slot_q <= '0;
			run_flag_q <= 1'b1;
			out_valid_q <= 1'b0;
			cmd_q <= pets_pkg::CMD_CREATE;
			chk_q <= '0;
			pli_q <= '0;
			full_q <= 1'b0;
			nt_q <= '0;
			np_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				dq_q <= cfg_wr_data;
			end
			if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= pets_pkg::cmd_t'(cmd);
						full_q <= 1'b0;
						nt_q <= '0;
						np_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FIN;
					case (cmd_q)
						pets_pkg::CMD_CREATE: begin
							if (free_found) begin
								use_q[free_slot] <= 1'b1;
								sleep_q[free_slot] <= 1'b0;
								nt_q <= free_slot;
							end else begin
								full_q <= 1'b1;
							end
						end
						pets_pkg::CMD_TICK: begin
							tick_q <= tick_q + 32'd1;
							chk_q <= '0;
							state_q <= S_TSCAN;
						end
						pets_pkg::CMD_YIELD: begin
							state_q <= run_flag_q ? S_CHG : S_DISP;
						end
						pets_pkg::CMD_SLEEP: begin
							if (run_flag_q && ticks != '0) begin
								sleep_q[run_slot_q] <= 1'b1;
								state_q <= S_CHG;
							end
						end
						pets_pkg::CMD_EXIT: begin
							if (run_flag_q) begin
								use_q[run_slot_q] <= 1'b0;
								sleep_q[run_slot_q] <= 1'b0;
								state_q <= S_DISP;
							end
						end
						pets_pkg::CMD_NICE: begin
							if (run_flag_q) begin
								state_q <= S_CHG;
							end
						end
						default: begin
						end
					endcase
				end
				S_TSCAN: begin
					if (scan_hit) begin
						sleep_q[chk_q] <= 1'b0;
					end
					chk_q <= chk_q + SW'(1);
					if (chk_q == SW'(NT - 1)) begin
						state_q <= run_flag_q ? S_CHG : S_DISP;
					end
				end
				S_CHG: begin
					if (cmd_q == pets_pkg::CMD_NICE) begin
						np_q <= pets_pkg::clamp_sum(thr_rdata.base, nice_q);
						state_q <= S_FIN;
					end else begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (use_b) begin
						epoch_q <= ~epoch_q;
					end
					if (disp_found) begin
						run_flag_q <= 1'b1;
						run_slot_q <= head_q[disp_li];
						pli_q <= disp_li;
						state_q <= (head_q[disp_li] == tail_q[disp_li]) ? S_FIN : S_POPW;
					end else begin
						run_flag_q <= 1'b0;
						run_slot_q <= '0;
						state_q <= S_FIN;
					end
				end
				S_POPW: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload and sleep length product.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			prio_q <= priority_req;
			nice_q <= nice_value;
			prod_q <= {16'd0, sleep_time} * {16'd0, pets_pkg::DIV_MUL};
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
			out_thread_q <= run_flag_q ? 4'(run_slot_q) : 4'd0;
			out_run_q <= run_flag_q;
			out_nt_q <= 4'(nt_q);
			out_np_q <= 4'(np_q);
			if (full_q) begin
				out_stat_q <= pets_pkg::STAT_FULL;
			end else if (run_flag_q) begin
				out_stat_q <= pets_pkg::STAT_OK;
			end else if (use_q != '0) begin
				out_stat_q <= pets_pkg::STAT_IDLE;
			end else begin
				out_stat_q <= pets_pkg::STAT_DONE;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign running_thread = out_thread_q;
	assign running_valid = out_run_q;
	assign status = out_stat_q;
	assign created_slot = out_nt_q;
	assign new_priority = out_np_q;

	// The running thread is always a live slot between requests.
	a_run_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && run_flag_q) |-> use_q[run_slot_q])
		else $error("running thread is not in use");

	// The running thread never sleeps between requests.
	a_run_awake: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && run_flag_q) |-> !sleep_q[run_slot_q])
		else $error("running thread is asleep");

	// A good status comes only with a running thread.
	a_ok_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == pets_pkg::STAT_OK) |-> running_valid)
		else $error("status ok without a running thread");

	// A pop that continues into a head update never empties its list.
	a_popw_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POPW) |-> ne_q[pli_q])
		else $error("head update on an empty list");

endmodule

@@ hw/rtl/pets_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module pets_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the priority epoch thread scheduler unit.
`timescale 1ns / 1ps
module tb;

	// Command values outside the defined set; the block must ignore them.
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 30;

	typedef struct {
		logic [3:0] thread;
		logic       valid;
		logic [1:0] stat;
		logic [3:0] created;
		logic [3:0] prio;
	} sched_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] cmd = 3'd0;
	logic signed [5:0] priority_req = 6'sd0;
	logic signed [5:0] nice_value = 6'sd0;
	logic [15:0] sleep_time = 16'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] running_thread;
	logic running_valid;
	logic [1:0] status;
	logic [3:0] created_slot;
	logic [3:0] new_priority;

	// Shadow copy of the scheduler state.
	logic [7:0] quantum_reg;
	logic slot_used [pets_pkg::MAX_THREADS];
	logic [3:0] base_lv [pets_pkg::MAX_THREADS];
	logic [3:0] cur_lv [pets_pkg::MAX_THREADS];
	logic [7:0] quant [pets_pkg::MAX_THREADS];
	logic signed [5:0] nice_off [pets_pkg::MAX_THREADS];
	logic [31:0] wake_at [pets_pkg::MAX_THREADS];
	logic sleeping [pets_pkg::MAX_THREADS];
	logic [3:0] link [pets_pkg::MAX_THREADS];
	logic [3:0] head [pets_pkg::NUM_LISTS];
	logic [3:0] tail [pets_pkg::NUM_LISTS];
	logic nonempty [pets_pkg::NUM_LISTS];
	logic epoch;
	logic [31:0] tick_cnt;
	logic [3:0] run_slot;
	logic run_on;

	sched_result_t pending_results [$];
	int error_count = 0;
	int burst_left = 4;
	int idle_cycles = 0;
	logic [8:0] stall_cnt = '0;

	priority_epoch_thread_scheduler_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .priority_req(priority_req), .nice_value(nice_value),
		.sleep_time(sleep_time),
		.out_valid(out_valid), .out_stall(out_stall),
		.running_thread(running_thread), .running_valid(running_valid),
		.status(status), .created_slot(created_slot), .new_priority(new_priority)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Clamp a signed sum to the priority level range.
	function automatic logic [3:0] clamp_level(int v);
		if (v < 0) return 4'd0;
		if (v >= pets_pkg::PRIO_LEVELS) return 4'(pets_pkg::PRIO_LEVELS - 1);
		return 4'(v);
	endfunction

	function automatic void list_append(logic bank, logic [3:0] lvl, logic [3:0] s);
		int li;
		li = (bank ? pets_pkg::PRIO_LEVELS : 0) + int'(lvl);
		if (nonempty[li]) begin
			link[tail[li]] = s;
			tail[li] = s;
		end else begin
			head[li] = s;
			tail[li] = s;
			nonempty[li] = 1'b1;
		end
	endfunction

	function automatic bit take_active_head();
		int li;
		for (int p = 0; p < pets_pkg::PRIO_LEVELS; p++) begin
			li = (epoch ? pets_pkg::PRIO_LEVELS : 0) + p;
			if (nonempty[li]) begin
				run_slot = head[li];
				if (head[li] == tail[li]) nonempty[li] = 1'b0;
				else head[li] = link[head[li]];
				run_on = 1'b1;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Pick the next thread, swapping the active and expired sets once if needed.
	function automatic void pick_next();
		run_on = 1'b0;
		run_slot = 4'd0;
		if (!take_active_head()) begin
			epoch = ~epoch;
			void'(take_active_head());
		end
	endfunction

	// Charge one quantum unit; returns 1 when the quantum was spent and refilled.
	function automatic bit charge_quantum(logic [3:0] s);
		if (quant[s] <= 8'd1) begin
			quant[s] = quantum_reg;
			cur_lv[s] = clamp_level(int'(base_lv[s]) + int'(nice_off[s]));
			return 1'b1;
		end
		quant[s] = quant[s] - 8'd1;
		return 1'b0;
	endfunction

	function automatic void yield_running();
		if (run_on) begin
			if (charge_quantum(run_slot)) list_append(~epoch, cur_lv[run_slot], run_slot);
			else list_append(epoch, cur_lv[run_slot], run_slot);
		end
		pick_next();
	endfunction

	function automatic void reset_schedule();
		for (int s = 0; s < pets_pkg::MAX_THREADS; s++) begin
			slot_used[s] = 1'b0;
			sleeping[s] = 1'b0;
		end
		for (int i = 0; i < pets_pkg::NUM_LISTS; i++) nonempty[i] = 1'b0;
		quantum_reg = pets_pkg::DEF_QUANT;
		slot_used[0] = 1'b1;
		base_lv[0] = 4'd0;
		cur_lv[0] = 4'd0;
		nice_off[0] = 6'sd0;
		quant[0] = pets_pkg::DEF_QUANT;
		epoch = 1'b0;
		tick_cnt = 32'd1;
		run_slot = 4'd0;
		run_on = 1'b1;
	endfunction

	// Work out the result of one accepted request and queue it.
	function automatic void schedule_request(logic [2:0] c, logic signed [5:0] preq,
		logic signed [5:0] nv, logic [15:0] st);
		sched_result_t r;
		bit full;
		bit any_used;
		logic [3:0] lv;
		logic [31:0] ticks;
		full = 1'b0;
		r.created = 4'd0;
		r.prio = 4'd0;
		case (c)
			pets_pkg::CMD_CREATE: begin
				full = 1'b1;
				for (int s = 0; s < pets_pkg::MAX_THREADS; s++) begin
					if (full && !slot_used[s]) begin
						lv = clamp_level(int'(preq));
						slot_used[s] = 1'b1;
						base_lv[s] = lv;
						cur_lv[s] = lv;
						quant[s] = quantum_reg;
						nice_off[s] = 6'sd0;
						sleeping[s] = 1'b0;
						list_append(epoch, lv, 4'(s));
						r.created = 4'(s);
						full = 1'b0;
					end
				end
			end
			pets_pkg::CMD_TICK: begin
				tick_cnt = tick_cnt + 32'd1;
				for (int s = 0; s < pets_pkg::MAX_THREADS; s++) begin
					if (slot_used[s] && sleeping[s] && wake_at[s] == tick_cnt) begin
						sleeping[s] = 1'b0;
						list_append(epoch, cur_lv[s], 4'(s));
					end
				end
				yield_running();
			end
			pets_pkg::CMD_YIELD: yield_running();
			pets_pkg::CMD_SLEEP: begin
				ticks = 32'(st / 16'd10);
				if (run_on && ticks != 32'd0) begin
					wake_at[run_slot] = tick_cnt + ticks;
					sleeping[run_slot] = 1'b1;
					void'(charge_quantum(run_slot));
					pick_next();
				end
			end
			pets_pkg::CMD_EXIT: begin
				if (run_on) begin
					slot_used[run_slot] = 1'b0;
					sleeping[run_slot] = 1'b0;
					pick_next();
				end
			end
			pets_pkg::CMD_NICE: begin
				if (run_on) begin
					nice_off[run_slot] = nv;
					cur_lv[run_slot] = clamp_level(int'(base_lv[run_slot]) + int'(nv));
					r.prio = cur_lv[run_slot];
				end
			end
			default: ;
		endcase
		any_used = 1'b0;
		for (int s = 0; s < pets_pkg::MAX_THREADS; s++) if (slot_used[s]) any_used = 1'b1;
		if (full) r.stat = pets_pkg::STAT_FULL;
		else if (run_on) r.stat = pets_pkg::STAT_OK;
		else r.stat = any_used ? pets_pkg::STAT_IDLE : pets_pkg::STAT_DONE;
		r.thread = run_on ? run_slot : 4'd0;
		r.valid = run_on;
		pending_results.push_back(r);
	endfunction

	// Send one request in the current burst; gaps fall between bursts.
	task automatic send_request(logic [2:0] c, logic signed [5:0] preq,
		logic signed [5:0] nv, logic [15:0] st);
		in_valid <= 1'b1;
		cmd <= c;
		priority_req <= preq;
		nice_value <= nv;
		sleep_time <= st;
		do @(posedge clk); while (in_stall);
		schedule_request(c, preq, nv, st);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
	endtask

	// Stop sending and wait until every queued result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_quantum(logic [7:0] q);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= q;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		quantum_reg = q;
	endtask

	task automatic test_directed();
		send_request(pets_pkg::CMD_YIELD, 6'sd0, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_NICE, 6'sd0, -6'sd20, 16'd0);
		send_request(pets_pkg::CMD_NICE, 6'sd0, 6'sd19, 16'd0);
		// Last thread leaves: everything exited, then commands while idle.
		send_request(pets_pkg::CMD_EXIT, 6'sd0, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_SLEEP, 6'sd0, 6'sd0, 16'd20);
		send_request(pets_pkg::CMD_EXIT, 6'sd0, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_NICE, 6'sd0, 6'sd5, 16'd0);
		send_request(pets_pkg::CMD_YIELD, 6'sd0, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_TICK, 6'sd0, 6'sd0, 16'd0);
		// Creating while idle does not start the thread; a yield does.
		send_request(pets_pkg::CMD_CREATE, -6'sd16, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_YIELD, 6'sd0, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_CREATE, 6'sd31, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_CREATE, 6'sd14, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_CREATE, 6'sd15, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_SLEEP, 6'sd0, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_SLEEP, 6'sd0, 6'sd0, 16'd9);
		send_request(CMD_RSVD6, 6'sd0, 6'sd0, 16'd0);
		send_request(CMD_RSVD7, 6'sd0, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_SLEEP, 6'sd0, 6'sd0, 16'd20);
		send_request(pets_pkg::CMD_TICK, 6'sd0, 6'sd0, 16'd0);
		send_request(pets_pkg::CMD_TICK, 6'sd0, 6'sd0, 16'd0);
		// A sleep that never ends keeps its slot for the rest of the run.
		send_request(pets_pkg::CMD_SLEEP, 6'sd0, 6'sd0, 16'hFFFF);
		send_request(pets_pkg::CMD_YIELD, 6'sd0, 6'sd0, 16'd0);
	endtask

	// Ask for one more thread than the table has slots, so that it fills and later creates find it full.
	task automatic test_full_table();
		repeat (pets_pkg::MAX_THREADS + 1) send_request(pets_pkg::CMD_CREATE,
			6'($urandom_range(0, 47) - 16), 6'sd0, 16'd0);
		repeat (6) send_request(pets_pkg::CMD_EXIT, 6'sd0, 6'sd0, 16'd0);
	endtask

	task automatic test_random(int n);
		int pick;
		logic [2:0] c;
		logic [15:0] st;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 18) c = pets_pkg::CMD_CREATE;
			else if (pick < 40) c = pets_pkg::CMD_TICK;
			else if (pick < 60) c = pets_pkg::CMD_YIELD;
			else if (pick < 73) c = pets_pkg::CMD_SLEEP;
			else if (pick < 86) c = pets_pkg::CMD_EXIT;
			else if (pick < 96) c = pets_pkg::CMD_NICE;
			else c = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
			// Mostly short sleeps so that sleepers wake; now and then any length.
			if ($urandom_range(0, 29) == 0) st = 16'($urandom);
			else st = 16'($urandom_range(0, 59));
			send_request(c, 6'($urandom_range(0, 47) - 16),
				6'($urandom_range(0, 39) - 20), st);
		end
	endtask

	// Receiver stall pattern: free flow, sparse, periodic and heavy stretches.
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 9'd1;
		case (stall_cnt[8:7])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 3) == 0);
			2'd2: out_stall <= (stall_cnt[1:0] == 2'd0);
			default: out_stall <= $urandom_range(0, 1);
		endcase
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		sched_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result thread=%0d valid=%0b status=%0d",
					$time, running_thread, running_valid, status);
				error_count++;
			end else begin
				e = pending_results.pop_front();
				if (running_thread !== e.thread || running_valid !== e.valid ||
					status !== e.stat || created_slot !== e.created ||
					new_priority !== e.prio) begin
					$display("%0t: mismatch expected thread=%0d valid=%0b status=%0d new=%0d prio=%0d",
						$time, e.thread, e.valid, e.stat, e.created, e.prio);
					$display("%0t:          actual thread=%0d valid=%0b status=%0d new=%0d prio=%0d",
						$time, running_thread, running_valid, status, created_slot,
						new_priority);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted request or result.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		reset_schedule();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_table();
		set_quantum(8'd1);
		test_random(110);
		set_quantum(8'd255);
		test_random(90);
		set_quantum(8'd0);
		test_random(80);
		set_quantum(8'($urandom_range(2, 254)));
		test_random(80);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
